>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the sample player block. Checks are compiled out
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk_sig, rst_sig, cond, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, clk_sig, rst_sig, prop, msg)

`define ASSERT_NEVER(label, clk_sig, rst_sig, cond, msg)

`endif

`endif

>>> rtl/tclsp_pkg.sv
// ----------------------------------------------------------------------------
// tclsp_pkg
// Shared types and constants of the two-channel looping sample player.
// ----------------------------------------------------------------------------
package tclsp_pkg;

  // field widths
  localparam int ADDR_W = 24;
  localparam int NUM_CH = 2;
  localparam int MODE_W = 2;
  localparam int VOL_W  = 5;
  localparam int PAN_W  = 8;
  localparam int CW_W   = 16;
  localparam int CFG_IDX_W = 3;

  // volume and panning thresholds
  localparam int VOLUME_MAX = 16;
  localparam logic [VOL_W-1:0] VOLUME_HALF = VOL_W'(VOLUME_MAX / 2);
  localparam logic signed [PAN_W-1:0] PAN_LIMIT     = 8'sd64;
  localparam logic signed [PAN_W-1:0] PAN_LIMIT_NEG = -8'sd64;

  // control word layout
  localparam int CW_VOL_LSB   = 2;
  localparam int CW_EN_LSB    = 8;
  localparam int CW_EN_STRIDE = 4;

  // item kinds
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PLAY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOL_1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_0  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PAN_1  = 3'd5;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              channel;
    logic [ADDR_W-1:0] start_address;
    logic [ADDR_W-1:0] length;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] fetch_address_0;
    logic              fetch_valid_0;
    logic [ADDR_W-1:0] fetch_address_1;
    logic              fetch_valid_1;
    logic              restart_0;
    logic              restart_1;
    logic [CW_W-1:0]   control_word;
  } out_item_t;

  // register file contents, one entry per channel
  typedef struct packed {
    logic [NUM_CH-1:0][ADDR_W-1:0] loop_span;
    logic [NUM_CH-1:0][VOL_W-1:0]  volume_level;
    logic [NUM_CH-1:0][PAN_W-1:0]  pan_position;
  } cfg_t;

endpackage

>>> rtl/tclsp_cfg_regs.sv
// ----------------------------------------------------------------------------
// tclsp_cfg_regs
// Configuration register file: loop lengths, volume levels and panning.
// ----------------------------------------------------------------------------
module tclsp_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_en,
  input  logic [tclsp_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [tclsp_pkg::ADDR_W-1:0]        cfg_data,
  output tclsp_pkg::cfg_t                     cfg
);

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loop_span    <= '0;
      cfg.volume_level <= {tclsp_pkg::NUM_CH{tclsp_pkg::VOL_W'(tclsp_pkg::VOLUME_MAX)}};
      cfg.pan_position <= '0;
    end else if (cfg_en) begin
      unique case (cfg_addr)
        tclsp_pkg::REG_LOOP_0: cfg.loop_span[0]    <= cfg_data;
        tclsp_pkg::REG_LOOP_1: cfg.loop_span[1]    <= cfg_data;
        tclsp_pkg::REG_VOL_0:  cfg.volume_level[0] <= cfg_data[tclsp_pkg::VOL_W-1:0];
        tclsp_pkg::REG_VOL_1:  cfg.volume_level[1] <= cfg_data[tclsp_pkg::VOL_W-1:0];
        tclsp_pkg::REG_PAN_0:  cfg.pan_position[0] <= cfg_data[tclsp_pkg::PAN_W-1:0];
        tclsp_pkg::REG_PAN_1:  cfg.pan_position[1] <= cfg_data[tclsp_pkg::PAN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/tclsp_core.sv
// ----------------------------------------------------------------------------
// tclsp_core
// Channel state and the combinational update for one item: fetch addresses,
// position advance with loop or stop at the end, and the control word.
// ----------------------------------------------------------------------------
module tclsp_core (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  tclsp_pkg::in_item_t    item,
  input  tclsp_pkg::cfg_t        cfg,
  output tclsp_pkg::out_item_t   result
);

  logic [tclsp_pkg::ADDR_W-1:0] play_position      [tclsp_pkg::NUM_CH];
  logic [tclsp_pkg::ADDR_W-1:0] end_position       [tclsp_pkg::NUM_CH];
  logic [tclsp_pkg::NUM_CH-1:0] channel_active;
  logic [tclsp_pkg::ADDR_W-1:0] play_position_next [tclsp_pkg::NUM_CH];
  logic [tclsp_pkg::ADDR_W-1:0] end_position_next  [tclsp_pkg::NUM_CH];
  logic [tclsp_pkg::NUM_CH-1:0] channel_active_next;

  logic [tclsp_pkg::ADDR_W-1:0] advanced   [tclsp_pkg::NUM_CH];
  logic [tclsp_pkg::ADDR_W-1:0] loop_target[tclsp_pkg::NUM_CH];
  logic [tclsp_pkg::ADDR_W-1:0] fetch_addr [tclsp_pkg::NUM_CH];
  logic [tclsp_pkg::NUM_CH-1:0] fetch_valid;
  logic [tclsp_pkg::NUM_CH-1:0] restart;
  logic [tclsp_pkg::CW_W-1:0]   control_word;

  // per-channel state update, channels are independent
  always_comb begin
    for (int c = 0; c < tclsp_pkg::NUM_CH; c++) begin
      advanced[c]           = play_position[c] + 1'b1;
      loop_target[c]        = end_position[c] - cfg.loop_span[c];
      play_position_next[c] = play_position[c];
      end_position_next[c]  = end_position[c];
      channel_active_next[c] = channel_active[c];
      fetch_addr[c]         = '0;
      fetch_valid[c]        = 1'b0;
      restart[c]            = 1'b0;
      unique case (item.mode)
        tclsp_pkg::MODE_TICK: begin
          if (channel_active[c]) begin
            fetch_addr[c]  = play_position[c];
            fetch_valid[c] = 1'b1;
            if (advanced[c] == end_position[c]) begin
              if (cfg.loop_span[c] != '0) begin
                play_position_next[c] = loop_target[c];
                restart[c]            = 1'b1;
              end else begin
                play_position_next[c]  = advanced[c];
                channel_active_next[c] = 1'b0;
              end
            end else begin
              play_position_next[c] = advanced[c];
            end
          end
        end
        tclsp_pkg::MODE_PLAY: begin
          if (item.channel == 1'(c)) begin
            if (item.length == '0) begin
              channel_active_next[c] = 1'b0;
            end else begin
              play_position_next[c]  = item.start_address;
              end_position_next[c]   = item.start_address + item.length;
              channel_active_next[c] = 1'b1;
              restart[c]             = 1'b1;
            end
          end
        end
        tclsp_pkg::MODE_STOP: begin
          if (item.channel == 1'(c)) begin
            channel_active_next[c] = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // control word from volume, panning and the updated active bits
  always_comb begin
    control_word = '0;
    for (int c = 0; c < tclsp_pkg::NUM_CH; c++) begin
      control_word[tclsp_pkg::CW_VOL_LSB + c] =
        (cfg.volume_level[c] > tclsp_pkg::VOLUME_HALF);
      if (channel_active_next[c]) begin
        control_word[tclsp_pkg::CW_EN_LSB + tclsp_pkg::CW_EN_STRIDE * c + 1] =
          ($signed(cfg.pan_position[c]) < tclsp_pkg::PAN_LIMIT);
        control_word[tclsp_pkg::CW_EN_LSB + tclsp_pkg::CW_EN_STRIDE * c] =
          ($signed(cfg.pan_position[c]) > tclsp_pkg::PAN_LIMIT_NEG);
      end
    end
  end

  // result beat
  always_comb begin
    result.fetch_address_0 = fetch_addr[0];
    result.fetch_valid_0   = fetch_valid[0];
    result.fetch_address_1 = fetch_addr[1];
    result.fetch_valid_1   = fetch_valid[1];
    result.restart_0       = restart[0];
    result.restart_1       = restart[1];
    result.control_word    = control_word;
  end

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_active <= '0;
      for (int c = 0; c < tclsp_pkg::NUM_CH; c++) begin
        play_position[c] <= '0;
        end_position[c]  <= '0;
      end
    end else if (step) begin
      channel_active <= channel_active_next;
      for (int c = 0; c < tclsp_pkg::NUM_CH; c++) begin
        play_position[c] <= play_position_next[c];
        end_position[c]  <= end_position_next[c];
      end
    end
  end

endmodule

>>> rtl/two_channel_looping_sample_player.sv
// ----------------------------------------------------------------------------
// two_channel_looping_sample_player
// Two-channel looping sample playback address generator: input register,
// channel update and result register.
// ----------------------------------------------------------------------------
// Takes one beat per clock cycle while the output is not stalled and returns
// exactly one result beat for each, in order. A beat taken into the input
// register has its channel state update and control word worked out while
// it is held there and captured in the result register once that register
// is free. The rate of one beat per cycle rests on the channel position
// registers being updated as a beat moves on, so the next beat reads them at
// once. Configuration registers may be written only while no beat is in
// flight; the control word of each result reflects them and the channel
// state after that beat.
`include "assert_macros.svh"

module two_channel_looping_sample_player (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tclsp_pkg::in_item_t               in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tclsp_pkg::out_item_t              out_item,
  input  logic                              cfg_en,
  input  logic [tclsp_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [tclsp_pkg::ADDR_W-1:0]      cfg_data
);

  logic                   s1_valid;
  tclsp_pkg::in_item_t    s1_item;
  logic                   s1_en;
  logic                   s2_en;
  logic                   step;
  tclsp_pkg::cfg_t        cfg;
  tclsp_pkg::out_item_t   result;

  // handshake: the result register frees when empty or taken
  assign s2_en    = !out_valid || !out_stall;
  assign step     = s1_valid && s2_en;
  assign s1_en    = !s1_valid || s2_en;
  assign in_stall = !s1_en;

  tclsp_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg_en   (cfg_en),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  tclsp_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (s1_item),
    .cfg    (cfg),
    .result (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en && in_valid) begin
      s1_item <= in_item;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= result;
    end
  end

  // a beat leaving the input register lands in the result register
  `ASSERT_PROP(a_step_fills_out, clk, rst, step |=> out_valid,
               "beat lost after input register")

  // only a tick fetches
  `ASSERT_PROP(a_fetch_on_tick, clk, rst,
               step && (s1_item.mode != tclsp_pkg::MODE_TICK)
                 |=> !out_item.fetch_valid_0 && !out_item.fetch_valid_1,
               "fetch flagged on non-tick beat")

  // a stop never flags a fifo restart
  `ASSERT_PROP(a_no_restart_on_stop, clk, rst,
               step && (s1_item.mode == tclsp_pkg::MODE_STOP)
                 |=> !out_item.restart_0 && !out_item.restart_1,
               "restart flagged on stop beat")

  // the input side stalls only while the input register is held
  `ASSERT_NEVER(a_stall_without_item, clk, rst,
                in_stall && !(s1_valid && out_valid && out_stall),
                "input stalled without a held beat")

endmodule

>>> verif/two_channel_looping_sample_player_test.sv
// ----------------------------------------------------------------------------
// two_channel_looping_sample_player_test
// Self-checking bench for the two-channel sample player. A behavioural copy
// of the channel sequencer predicts every result beat from the accepted input
// beats; a monitor compares each result field by field. Directed beats cover
// single-shot playback, address wrap, looping and zero-length plays; random
// phases under varied settings, bursty input and output stalls follow.
// ----------------------------------------------------------------------------
module two_channel_looping_sample_player_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 40;
  localparam logic [tclsp_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

  // clock, reset and block ports
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  tclsp_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  tclsp_pkg::out_item_t out_item;
  logic cfg_en = 1'b0;
  logic [tclsp_pkg::CFG_IDX_W-1:0] cfg_addr = '0;
  logic [tclsp_pkg::ADDR_W-1:0] cfg_data = '0;

  // predictor copy of registers and channel state
  logic [tclsp_pkg::ADDR_W-1:0] loop_len [tclsp_pkg::NUM_CH] = '{default: '0};
  logic [tclsp_pkg::VOL_W-1:0] vol_level [tclsp_pkg::NUM_CH] =
    '{default: tclsp_pkg::VOL_W'(tclsp_pkg::VOLUME_MAX)};
  logic signed [tclsp_pkg::PAN_W-1:0] pan_pos [tclsp_pkg::NUM_CH] = '{default: '0};
  logic [tclsp_pkg::ADDR_W-1:0] play_pos [tclsp_pkg::NUM_CH] = '{default: '0};
  logic [tclsp_pkg::ADDR_W-1:0] end_pos [tclsp_pkg::NUM_CH] = '{default: '0};
  logic ch_active [tclsp_pkg::NUM_CH] = '{default: 1'b0};

  tclsp_pkg::out_item_t predicted_outputs [$];

  // pacing of both sides
  int gap_max = 0;
  int burst_max = 1;
  int burst_left = 0;
  int stall_pct = 0;
  int stall_run = 0;
  int hold_request = 0;
  int hold_left = 0;

  // bookkeeping
  int cycle_count = 0;
  int mismatches = 0;
  int items_sent = 0;
  int directed_items = 0;
  int results_checked = 0;
  int loop_restarts = 0;
  int sound_ends = 0;
  int settings_loaded = 0;
  int stalled_offers = 0;

  two_channel_looping_sample_player DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_en   (cfg_en),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // control word from the current registers and active bits
  function automatic logic [tclsp_pkg::CW_W-1:0] control_bits();
    logic [tclsp_pkg::CW_W-1:0] cw;
    cw = '0;
    for (int c = 0; c < tclsp_pkg::NUM_CH; c++) begin
      if (vol_level[c] > tclsp_pkg::VOLUME_HALF) cw[tclsp_pkg::CW_VOL_LSB + c] = 1'b1;
      if (ch_active[c]) begin
        cw[tclsp_pkg::CW_EN_LSB + tclsp_pkg::CW_EN_STRIDE * c + 1] =
          (pan_pos[c] < tclsp_pkg::PAN_LIMIT);
        cw[tclsp_pkg::CW_EN_LSB + tclsp_pkg::CW_EN_STRIDE * c] =
          (pan_pos[c] > tclsp_pkg::PAN_LIMIT_NEG);
      end
    end
    return cw;
  endfunction

  // one beat through the channel sequencer, returns its result
  function automatic tclsp_pkg::out_item_t advance_channels(input tclsp_pkg::in_item_t beat);
    tclsp_pkg::out_item_t res;
    logic [tclsp_pkg::ADDR_W-1:0] addr [tclsp_pkg::NUM_CH];
    logic fetch [tclsp_pkg::NUM_CH];
    logic restart [tclsp_pkg::NUM_CH];
    for (int c = 0; c < tclsp_pkg::NUM_CH; c++) begin
      addr[c] = '0;
      fetch[c] = 1'b0;
      restart[c] = 1'b0;
    end
    case (beat.mode)
      tclsp_pkg::MODE_TICK: begin
        for (int c = 0; c < tclsp_pkg::NUM_CH; c++) begin
          if (ch_active[c]) begin
            addr[c] = play_pos[c];
            fetch[c] = 1'b1;
            play_pos[c] = play_pos[c] + 1'b1;
            if (play_pos[c] == end_pos[c]) begin
              if (loop_len[c] != '0) begin
                play_pos[c] = end_pos[c] - loop_len[c];
                restart[c] = 1'b1;
                loop_restarts++;
              end else begin
                ch_active[c] = 1'b0;
                sound_ends++;
              end
            end
          end
        end
      end
      tclsp_pkg::MODE_PLAY: begin
        // zero length behaves as a stop, no restart
        if (beat.length == '0) begin
          ch_active[beat.channel] = 1'b0;
        end else begin
          play_pos[beat.channel] = beat.start_address;
          end_pos[beat.channel] = beat.start_address + beat.length;
          ch_active[beat.channel] = 1'b1;
          restart[beat.channel] = 1'b1;
        end
      end
      tclsp_pkg::MODE_STOP: begin
        ch_active[beat.channel] = 1'b0;
      end
      default: begin
        // unused item kind leaves the channels alone
      end
    endcase
    res.fetch_address_0 = addr[0];
    res.fetch_valid_0   = fetch[0];
    res.fetch_address_1 = addr[1];
    res.fetch_valid_1   = fetch[1];
    res.restart_0       = restart[0];
    res.restart_1       = restart[1];
    res.control_word    = control_bits();
    return res;
  endfunction

  function automatic tclsp_pkg::in_item_t make_beat(
      input logic [tclsp_pkg::MODE_W-1:0] mode, input logic ch,
      input logic [tclsp_pkg::ADDR_W-1:0] start,
      input logic [tclsp_pkg::ADDR_W-1:0] len);
    tclsp_pkg::in_item_t it;
    it.mode = mode;
    it.channel = ch;
    it.start_address = start;
    it.length = len;
    return it;
  endfunction

  // sound length: mostly short so that ends and loops come often
  function automatic logic [tclsp_pkg::ADDR_W-1:0] sound_length();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 2) return '0;
    if (pick < 4) return tclsp_pkg::ADDR_W'($urandom);
    return tclsp_pkg::ADDR_W'($urandom_range(1, 10));
  endfunction

  function automatic tclsp_pkg::in_item_t random_beat();
    tclsp_pkg::in_item_t it;
    int pick;
    it.start_address = tclsp_pkg::ADDR_W'($urandom);
    it.length = tclsp_pkg::ADDR_W'($urandom);
    it.channel = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 68) begin
      it.mode = tclsp_pkg::MODE_TICK;
    end else if (pick < 86) begin
      it.mode = tclsp_pkg::MODE_PLAY;
      it.length = sound_length();
      if ($urandom_range(0, 3) == 0)
        it.start_address = '1 - tclsp_pkg::ADDR_W'($urandom_range(0, 8));
    end else if (pick < 97) begin
      it.mode = tclsp_pkg::MODE_STOP;
    end else begin
      it.mode = MODE_UNUSED;
    end
    return it;
  endfunction

  function automatic logic [tclsp_pkg::ADDR_W-1:0] pick_loop();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return tclsp_pkg::ADDR_W'($urandom);
      default: return tclsp_pkg::ADDR_W'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [tclsp_pkg::VOL_W-1:0] pick_volume();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return tclsp_pkg::VOL_W'(tclsp_pkg::VOLUME_MAX);
      2: return tclsp_pkg::VOLUME_HALF;
      3: return tclsp_pkg::VOLUME_HALF + 1'b1;
      default: return tclsp_pkg::VOL_W'($urandom);
    endcase
  endfunction

  function automatic logic [tclsp_pkg::PAN_W-1:0] pick_pan();
    case ($urandom_range(0, 7))
      0: return tclsp_pkg::PAN_LIMIT;
      1: return tclsp_pkg::PAN_LIMIT_NEG;
      2: return tclsp_pkg::PAN_LIMIT - 1'b1;
      3: return tclsp_pkg::PAN_LIMIT_NEG + 1'b1;
      4: return '0;
      default: return tclsp_pkg::PAN_W'($urandom);
    endcase
  endfunction

  // offer one input beat, with burst/gap pacing, and record its prediction
  task automatic offer(input tclsp_pkg::in_item_t beat);
    int gap;
    if (gap_max > 0 && burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_item <= beat;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_outputs.push_back(advance_channels(beat));
    items_sent++;
  endtask

  // stop offering and let every predicted beat come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (predicted_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all six registers, only while nothing is in flight
  task automatic load_settings(
      input logic [tclsp_pkg::ADDR_W-1:0] loop0, input logic [tclsp_pkg::ADDR_W-1:0] loop1,
      input logic [tclsp_pkg::VOL_W-1:0] vol0, input logic [tclsp_pkg::VOL_W-1:0] vol1,
      input logic [tclsp_pkg::PAN_W-1:0] pan0, input logic [tclsp_pkg::PAN_W-1:0] pan1);
    logic [tclsp_pkg::ADDR_W-1:0] value;
    for (int r = tclsp_pkg::REG_LOOP_0; r <= tclsp_pkg::REG_PAN_1; r++) begin
      case (tclsp_pkg::CFG_IDX_W'(r))
        tclsp_pkg::REG_LOOP_0: value = loop0;
        tclsp_pkg::REG_LOOP_1: value = loop1;
        tclsp_pkg::REG_VOL_0:  value = tclsp_pkg::ADDR_W'(vol0);
        tclsp_pkg::REG_VOL_1:  value = tclsp_pkg::ADDR_W'(vol1);
        tclsp_pkg::REG_PAN_0:  value = tclsp_pkg::ADDR_W'(pan0);
        default:               value = tclsp_pkg::ADDR_W'(pan1);
      endcase
      cfg_en <= 1'b1;
      cfg_addr <= tclsp_pkg::CFG_IDX_W'(r);
      cfg_data <= value;
      @(posedge clk);
      case (tclsp_pkg::CFG_IDX_W'(r))
        tclsp_pkg::REG_LOOP_0: loop_len[0] = value;
        tclsp_pkg::REG_LOOP_1: loop_len[1] = value;
        tclsp_pkg::REG_VOL_0:  vol_level[0] = value[tclsp_pkg::VOL_W-1:0];
        tclsp_pkg::REG_VOL_1:  vol_level[1] = value[tclsp_pkg::VOL_W-1:0];
        tclsp_pkg::REG_PAN_0:  pan_pos[0] = value[tclsp_pkg::PAN_W-1:0];
        default:               pan_pos[1] = value[tclsp_pkg::PAN_W-1:0];
      endcase
    end
    cfg_en <= 1'b0;
    @(posedge clk);
    settings_loaded++;
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("mismatch in %s at result %0d: got %0h, predicted %0h",
               what, results_checked, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report(what, got, want);
  endtask

  // receiver: runs of stall or no stall, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      stall_run = $urandom_range(0, 6);
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    tclsp_pkg::out_item_t want;
    if (!rst && in_valid && in_stall) stalled_offers++;
    if (!rst && out_valid && !out_stall) begin
      if (predicted_outputs.size() == 0) begin
        report("unexpected result beat", 32'(out_item.control_word), '0);
      end else begin
        want = predicted_outputs.pop_front();
        check_field("fetch_address_0", 32'(out_item.fetch_address_0),
                    32'(want.fetch_address_0));
        check_field("fetch_valid_0", 32'(out_item.fetch_valid_0), 32'(want.fetch_valid_0));
        check_field("fetch_address_1", 32'(out_item.fetch_address_1),
                    32'(want.fetch_address_1));
        check_field("fetch_valid_1", 32'(out_item.fetch_valid_1), 32'(want.fetch_valid_1));
        check_field("restart_0", 32'(out_item.restart_0), 32'(want.restart_0));
        check_field("restart_1", 32'(out_item.restart_1), 32'(want.restart_1));
        check_field("control_word", 32'(out_item.control_word), 32'(want.control_word));
        results_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still awaited",
               cycle_count, predicted_outputs.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // reset settings: idle channels, a single-shot sound, wrap past the top
  task automatic test_single_shot();
    stall_pct = 30;
    gap_max = 0;
    offer(make_beat(tclsp_pkg::MODE_TICK, 1'b0, '0, '0));
    offer(make_beat(tclsp_pkg::MODE_PLAY, 1'b0, '0, 24'd2));
    repeat (3) offer(make_beat(tclsp_pkg::MODE_TICK, 1'b1, '1, '1));
    offer(make_beat(tclsp_pkg::MODE_PLAY, 1'b1, '1, 24'd2));
    repeat (2) offer(make_beat(tclsp_pkg::MODE_TICK, 1'b0, '0, '0));
    offer(make_beat(tclsp_pkg::MODE_PLAY, 1'b0, 24'd5, 24'd3));
    offer(make_beat(tclsp_pkg::MODE_PLAY, 1'b0, 24'd5, '0));
    offer(make_beat(tclsp_pkg::MODE_PLAY, 1'b1, 24'hABCDEF, '1));
    offer(make_beat(tclsp_pkg::MODE_TICK, 1'b0, '0, '0));
    offer(make_beat(tclsp_pkg::MODE_STOP, 1'b1, '0, '0));
    offer(make_beat(MODE_UNUSED, 1'b1, '1, '1));
  endtask

  // looping, loop longer than the sound, one-sided panning
  task automatic test_looping();
    wait_idle();
    load_settings(24'd1, 24'd5, '1, '0, tclsp_pkg::PAN_LIMIT, tclsp_pkg::PAN_LIMIT_NEG);
    offer(make_beat(tclsp_pkg::MODE_PLAY, 1'b0, 24'd100, 24'd2));
    offer(make_beat(tclsp_pkg::MODE_PLAY, 1'b1, '0, 24'd3));
    repeat (6) offer(make_beat(tclsp_pkg::MODE_TICK, 1'b0, '0, '0));
    offer(make_beat(tclsp_pkg::MODE_STOP, 1'b0, '0, '0));
    offer(make_beat(tclsp_pkg::MODE_TICK, 1'b1, '0, '0));
    offer(make_beat(tclsp_pkg::MODE_STOP, 1'b1, '1, '1));
    directed_items = items_sent;
  endtask

  // random phases, each under its own settings and pacing
  task automatic test_random_phases();
    for (int p = 0; p < 10; p++) begin
      wait_idle();
      if (p == 0)
        load_settings('0, '0, '0, tclsp_pkg::VOL_W'(tclsp_pkg::VOLUME_MAX), 8'sh7F, 8'sh80);
      else if (p == 1)
        load_settings('1, '1, tclsp_pkg::VOLUME_HALF, tclsp_pkg::VOLUME_HALF + 1'b1,
                      tclsp_pkg::PAN_LIMIT - 1'b1, tclsp_pkg::PAN_LIMIT_NEG + 1'b1);
      else
        load_settings(pick_loop(), pick_loop(), pick_volume(), pick_volume(),
                      pick_pan(), pick_pan());
      if (p % 3 == 0) begin
        gap_max = 0;
        stall_pct = 0;
      end else begin
        gap_max = $urandom_range(1, 8);
        burst_max = $urandom_range(1, 12);
        stall_pct = $urandom_range(10, 70);
      end
      burst_left = 0;
      repeat (150) offer(random_beat());
    end
  endtask

  // long receiver hold-off with the sender pushing, a full drain, then paced random beats with stalls
  task automatic test_back_pressure();
    wait_idle();
    load_settings(24'd3, 24'd2, pick_volume(), pick_volume(), pick_pan(), pick_pan());
    gap_max = 0;
    stall_pct = 0;
    hold_request = 300;
    repeat (80) offer(random_beat());
    wait_idle();
    gap_max = 4;
    burst_max = 6;
    stall_pct = 40;
    repeat (40) offer(random_beat());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_single_shot();
    test_looping();
    test_random_phases();
    test_back_pressure();
    wait_idle();
    repeat (8) @(posedge clk);
    $display("%0d beats sent (%0d directed), %0d results checked, %0d loop restarts, %0d ends",
             items_sent, directed_items, results_checked, loop_restarts, sound_ends);
    $display("%0d register settings, %0d cycles of input held off by the block",
             settings_loaded, stalled_offers);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
